[sv/lifegen_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lifegen_pkg
// Shared codes and controller/datapath interface types for the
// life generation block.
// ----------------------------------------------------------------------------
package lifegen_pkg;

    localparam int ROW_IDX_W = 4;
    localparam int ROW_BITS  = 16;
    localparam int CODE_W    = 2;

    // action codes
    localparam logic [CODE_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [CODE_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [CODE_W-1:0] ACT_READ    = 2'd2;

    // result kinds
    localparam logic [CODE_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [CODE_W-1:0] KIND_GEN  = 2'd1;
    localparam logic [CODE_W-1:0] KIND_READ = 2'd2;

    typedef struct packed {
        logic ld;        // load word accepted
        logic rd_issue;  // read word accepted, issue memory read
        logic rd_resp;   // read data is back
        logic adv_init;  // advance accepted, prime the sweep
        logic adv_step;  // one sweep cycle
    } t_cmd;

    typedef struct packed {
        logic adv_last;  // final sweep cycle
    } t_stat;

endpackage
`default_nettype wire

[sv/lifegen_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lifegen_ram
// Generic simple dual-port RAM, one write port, one read port with
// registered read data. Contents undefined until written.
// ----------------------------------------------------------------------------
module lifegen_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[sv/lifegen_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lifegen_ctrl
// Command sequencer: decodes accepted words and walks the read and
// generation sweeps.
// ----------------------------------------------------------------------------
module lifegen_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    input  wire logic [lifegen_pkg::CODE_W-1:0]  i_action,
    input  wire lifegen_pkg::t_stat              i_stat,
    output lifegen_pkg::t_cmd                    o_cmd,
    output logic                                 busy
);
    import lifegen_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ADV
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_action)
                        ACT_LOAD: begin
                            o_cmd.ld = 1'b1;
                        end
                        ACT_ADVANCE: begin
                            o_cmd.adv_init = 1'b1;
                            n_state        = S_ADV;
                        end
                        ACT_READ: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ;
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_resp = 1'b1;
                n_state       = S_IDLE;
            end
            S_ADV: begin
                o_cmd.adv_step = 1'b1;
                if (i_stat.adv_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

endmodule
`default_nettype wire

[sv/lifegen_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lifegen_dp
// Board storage, three-row window and per-column neighbor rule, result
// registers.
// ----------------------------------------------------------------------------
module lifegen_dp #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lifegen_pkg::t_cmd                  i_cmd,
    input  wire logic [lifegen_pkg::ROW_IDX_W-1:0]  i_row_index,
    input  wire logic [lifegen_pkg::ROW_BITS-1:0]   i_row_cells,
    output lifegen_pkg::t_stat                      o_stat,
    output logic                                    o_strobe,
    output logic [lifegen_pkg::CODE_W-1:0]          o_result_kind,
    output logic [lifegen_pkg::ROW_IDX_W-1:0]       o_result_row,
    output logic [lifegen_pkg::ROW_BITS-1:0]        o_result_cells
);
    import lifegen_pkg::*;

    localparam int AW = $clog2(GRID_ROWS);
    localparam int KW = $clog2(GRID_ROWS + 2);
    localparam int CW = 9;
    localparam logic [CW-1:0] ROWS_C = CW'(GRID_ROWS);
    localparam logic [KW-1:0] K_ROWS = KW'(GRID_ROWS);
    localparam logic [KW-1:0] K_LAST = KW'(GRID_ROWS + 1);
    localparam logic [KW-1:0] K_TWO  = KW'(2);
    localparam logic [KW-1:0] K_ONE  = KW'(1);

    // input decode
    logic                 in_range;
    logic [AW-1:0]        in_addr;
    logic [GRID_COLS-1:0] ld_row;
    logic [GRID_COLS+ROW_BITS-1:0] ld_ext;

    assign in_range = ({{(CW-ROW_IDX_W){1'b0}}, i_row_index} < ROWS_C);
    assign in_addr  = AW'({{(CW-ROW_IDX_W){1'b0}}, i_row_index});
    assign ld_ext   = {{GRID_COLS{1'b0}}, i_row_cells};
    assign ld_row   = ld_ext[GRID_COLS-1:0];

    // sweep state
    logic [KW-1:0]        r_k;
    logic [GRID_COLS-1:0] r_up, r_cur;
    logic [GRID_ROWS-1:0] r_valid;
    logic                 r_rd_ok;
    logic [ROW_IDX_W-1:0] r_row;

    logic k_lt_rows, k_ge_two, k_last;
    assign k_lt_rows = (r_k < K_ROWS);
    assign k_ge_two  = (r_k >= K_TWO);
    assign k_last    = (r_k == K_LAST);
    assign o_stat.adv_last = k_last;

    // memory ports
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [GRID_COLS-1:0] wdata, rdata, rdata_m;
    logic [KW-1:0]        k_m2;

    assign k_m2 = r_k - K_TWO;

    always_comb begin
        raddr = '0;
        if (i_cmd.rd_issue) begin
            raddr = in_addr;
        end else if (i_cmd.adv_step && k_lt_rows) begin
            raddr = r_k[AW-1:0];
        end
    end

    lifegen_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // rows never written read as dead
    assign rdata_m = r_rd_ok ? rdata : '0;

    // below-row: nothing past the bottom edge
    logic [GRID_COLS-1:0] dn;
    assign dn = k_last ? '0 : rdata_m;

    // neighbor rule, one column per slice
    logic [GRID_COLS+1:0] up_p, cur_p, dn_p;
    logic [GRID_COLS-1:0] nxt_row;
    assign up_p  = {1'b0, r_up,  1'b0};
    assign cur_p = {1'b0, r_cur, 1'b0};
    assign dn_p  = {1'b0, dn,    1'b0};

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        logic [3:0] n;
        assign n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
                 + 4'(cur_p[c])                + 4'(cur_p[c+2])
                 + 4'(dn_p[c])  + 4'(dn_p[c+1]) + 4'(dn_p[c+2]);
        assign nxt_row[c] = (n == 4'd3) || ((n == 4'd2) && r_cur[c]);
    end

    assign we    = (i_cmd.ld && in_range) || (i_cmd.adv_step && k_ge_two);
    assign waddr = i_cmd.ld ? in_addr : k_m2[AW-1:0];
    assign wdata = i_cmd.ld ? ld_row : nxt_row;

    // read data, low columns
    logic [GRID_COLS+ROW_BITS-1:0] rd_ext;
    assign rd_ext = {{ROW_BITS{1'b0}}, rdata_m};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_ok  <= 1'b0;
            o_strobe <= 1'b0;
            r_k      <= '0;
        end else begin
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            r_rd_ok <= r_valid[raddr] &&
                       (i_cmd.rd_issue ? in_range : (i_cmd.adv_init || k_lt_rows));
            o_strobe <= i_cmd.ld || i_cmd.rd_resp || (i_cmd.adv_step && k_last);
            if (i_cmd.adv_init) begin
                r_k <= K_ONE;
            end else if (i_cmd.adv_step) begin
                r_k <= r_k + K_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_row <= i_row_index;
        end
        if (i_cmd.adv_init) begin
            r_up  <= '0;
            r_cur <= '0;
        end else if (i_cmd.adv_step) begin
            r_up  <= r_cur;
            r_cur <= rdata_m;
        end
        if (i_cmd.ld) begin
            o_result_kind  <= KIND_LOAD;
            o_result_row   <= i_row_index;
            o_result_cells <= '0;
        end else if (i_cmd.rd_resp) begin
            o_result_kind  <= KIND_READ;
            o_result_row   <= r_row;
            o_result_cells <= rd_ext[ROW_BITS-1:0];
        end else if (i_cmd.adv_step && k_last) begin
            o_result_kind  <= KIND_GEN;
            o_result_row   <= '0;
            o_result_cells <= '0;
        end
    end

endmodule
`default_nettype wire

[sv/life_automaton_generation_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_generation_step
// Bounded life board: load row, advance one generation, read row.
// Load is answered in the cycle after acceptance; read after S_READ,
// advance after the sweep. busy: low after load, high in S_READ or in the
// sweep (one row per cycle through the single read port of the board RAM).
// Next word may start in the cycle its predecessor's result is shown.
// Synchronous reset clears the board at once (per-row valid bits).
// ----------------------------------------------------------------------------
module life_automaton_generation_step #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [lifegen_pkg::CODE_W-1:0]     i_action,
    input  wire logic [lifegen_pkg::ROW_IDX_W-1:0]  i_row_index,
    input  wire logic [lifegen_pkg::ROW_BITS-1:0]   i_row_cells,
    output logic                                    o_strobe,
    output logic [lifegen_pkg::CODE_W-1:0]          o_result_kind,
    output logic [lifegen_pkg::ROW_IDX_W-1:0]       o_result_row,
    output logic [lifegen_pkg::ROW_BITS-1:0]        o_result_cells
);
    import lifegen_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    lifegen_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    lifegen_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row_index    (i_row_index),
        .i_row_cells    (i_row_cells),
        .o_stat         (stat),
        .o_strobe       (o_strobe),
        .o_result_kind  (o_result_kind),
        .o_result_row   (o_result_row),
        .o_result_cells (o_result_cells)
    );

    // end of a multi-cycle word always comes with its result
    a_fell_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without result");

    a_load_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_LOAD) |=>
            (o_strobe && o_result_kind == KIND_LOAD))
        else $error("load not answered next cycle");

    a_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_ADVANCE) |=> (busy && !o_strobe))
        else $error("advance did not hold busy");

    a_gen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == KIND_GEN) |->
            (o_result_row == '0 && o_result_cells == '0))
        else $error("generation result carries data");

endmodule
`default_nettype wire
